>>> rtl/multi_button_debouncer_defines.svh
// assertion helpers for the multi-button debouncer
`ifndef MULTI_BUTTON_DEBOUNCER_DEFINES_SVH
`define MULTI_BUTTON_DEBOUNCER_DEFINES_SVH

`ifndef SYNTHESIS

`define MBD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mbd same-cycle check failed");

`define MBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mbd next-cycle check failed");

`else

`define MBD_ASSERT_IMP(label, ante, cons)

`define MBD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/mbd_pkg.sv
package mbd_pkg;

    localparam int BUTTON_COUNT_DEF = 4;
    localparam int BTN_IDX_W        = 4;
    localparam int PIN_W            = 4;
    localparam int TIME_W           = 32;
    localparam int CFG_ADDR_W       = 4;
    localparam int CFG_DATA_W       = 16;

    localparam logic [7:0]  PRESS_DB_RST   = 8'd10;
    localparam logic [7:0]  RELEASE_DB_RST = 8'd10;
    localparam logic [15:0] DOUBLE_TO_RST  = 16'd500;
    localparam logic        ACTIVE_LVL_RST = 1'b0;

    localparam logic [CFG_ADDR_W-1:0] CFG_PRESS_DB   = 4'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_DB = 4'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DOUBLE_TO  = 4'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_LVL = 4'd3;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_PRESS_DB   = 2'd1,
        PH_PRESSED    = 2'd2,
        PH_RELEASE_DB = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_POLL_START = 2'd0,
        KIND_PRESS      = 2'd1,
        KIND_COMBINED   = 2'd2,
        KIND_DONE       = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0]  press_db;
        logic [7:0]  release_db;
        logic [15:0] double_to;
        logic        active_lvl;
    } t_cfg;

    typedef struct packed {
        logic              edge_acc;
        logic              tick;
        logic              sel;
        logic              level;
        logic [TIME_W-1:0] now;
    } t_lane_cmd;

    typedef struct packed {
        logic started;
        logic held;
        logic busy;
    } t_lane_stat;

    typedef struct packed {
        logic                 edge_go;
        logic                 tick;
        logic                 busy_any;
        logic [BTN_IDX_W-1:0] btn;
    } t_merge_req;

endpackage

>>> rtl/multi_button_debouncer.sv
// an item's results pass the merge pending queue, then the output register
// one result beat per cycle while the output is ready; the input is held until every result
//   of the item has left the serial result queue in the merge stage
// a tick carries up to BUTTON_COUNT results; an edge at most two
// reset (sync, active low) sets every button idle, clears valid marks and polling,
//   and loads the register defaults
module multi_button_debouncer #(
    parameter int BUTTON_COUNT = mbd_pkg::BUTTON_COUNT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [39:0]                       s_axis_tdata, // btn_idx, now_ms, pin_levels
    input  logic [0:0]                        s_axis_tuser, // operation
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata, // button, polling_active, zero pad
    output logic [1:0]                        m_axis_tuser, // kind
    output logic                              m_axis_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mbd_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [mbd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    mbd_pkg::t_cfg                 r_cfg;
    logic                          in_acc;
    logic [mbd_pkg::BTN_IDX_W-1:0] in_idx;
    logic [mbd_pkg::TIME_W-1:0]    in_now;
    logic [mbd_pkg::PIN_W-1:0]     in_pins;
    logic [BUTTON_COUNT-1:0]       held;
    logic [BUTTON_COUNT-1:0]       busy;
    logic [BUTTON_COUNT-1:0]       started;
    logic [BUTTON_COUNT-1:0]       comb;
    mbd_pkg::t_merge_req           req;
    mbd_pkg::t_kind                out_kind;
    logic [1:0]                    out_btn;
    logic                          out_poll;
    logic                          merge_idle;

    assign in_idx  = s_axis_tdata[3:0];
    assign in_now  = s_axis_tdata[35:4];
    assign in_pins = s_axis_tdata[39:36];

    assign s_axis_tready = merge_idle;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_db   <= mbd_pkg::PRESS_DB_RST;
            r_cfg.release_db <= mbd_pkg::RELEASE_DB_RST;
            r_cfg.double_to  <= mbd_pkg::DOUBLE_TO_RST;
            r_cfg.active_lvl <= mbd_pkg::ACTIVE_LVL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                mbd_pkg::CFG_PRESS_DB:   r_cfg.press_db   <= i_cfg_data[7:0];
                mbd_pkg::CFG_RELEASE_DB: r_cfg.release_db <= i_cfg_data[7:0];
                mbd_pkg::CFG_DOUBLE_TO:  r_cfg.double_to  <= i_cfg_data[15:0];
                mbd_pkg::CFG_ACTIVE_LVL: r_cfg.active_lvl <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // lowest-index held button is not reported, every higher one is
    assign comb = held & (held - BUTTON_COUNT'(1));

    for (genvar g = 0; g < BUTTON_COUNT; g++) begin : g_lane
        mbd_pkg::t_lane_cmd  cmd;
        mbd_pkg::t_lane_stat stat;

        assign cmd.edge_acc = in_acc && (s_axis_tuser[0] == mbd_pkg::OP_EDGE);
        assign cmd.tick     = in_acc && (s_axis_tuser[0] == mbd_pkg::OP_TICK);
        assign cmd.sel      = (in_idx == mbd_pkg::BTN_IDX_W'(g));
        assign cmd.now      = in_now;
        if (g < mbd_pkg::PIN_W) begin : g_pin
            assign cmd.level = in_pins[g];
        end else begin : g_nopin
            assign cmd.level = 1'b0;
        end

        mbd_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd),
            .i_cfg   (r_cfg),
            .i_clear (comb[g]),
            .o_stat  (stat)
        );

        assign held[g]    = stat.held;
        assign busy[g]    = stat.busy;
        assign started[g] = stat.started;
    end

    assign req.edge_go  = |started;
    assign req.tick     = in_acc && (s_axis_tuser[0] == mbd_pkg::OP_TICK);
    assign req.busy_any = |busy;
    assign req.btn      = in_idx;

    mbd_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .i_comb        (comb),
        .i_tready      (m_axis_tready),
        .o_idle        (merge_idle),
        .o_valid       (m_axis_tvalid),
        .o_kind        (out_kind),
        .o_button      (out_btn),
        .o_poll_active (out_poll),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {5'd0, out_poll, out_btn};

endmodule

>>> rtl/mbd_lane.sv
module mbd_lane (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mbd_pkg::t_lane_cmd i_cmd,
    input  mbd_pkg::t_cfg      i_cfg,
    input  logic               i_clear,
    output mbd_pkg::t_lane_stat o_stat
);

    mbd_pkg::t_phase                 r_phase, n_phase;
    logic [mbd_pkg::TIME_W-1:0]      r_stamp, n_stamp;
    logic                            r_valid, n_valid;
    logic [mbd_pkg::TIME_W-1:0]      elapsed;
    logic                            pressed;
    logic                            press_done;
    logic                            release_done;

    // wraps modulo 2^32
    assign elapsed      = i_cmd.now - r_stamp;
    assign pressed      = (i_cmd.level == i_cfg.active_lvl);
    assign press_done   = (elapsed >= {24'd0, i_cfg.press_db});
    assign release_done = (elapsed >= {24'd0, i_cfg.release_db});

    always_comb begin
        o_stat.started = i_cmd.edge_acc && i_cmd.sel && (r_phase == mbd_pkg::PH_IDLE);
        o_stat.held    = (r_phase == mbd_pkg::PH_PRESSED) && r_valid
                         && (elapsed >= {16'd0, i_cfg.double_to});
        unique case (r_phase)
            mbd_pkg::PH_PRESS_DB:   o_stat.busy = 1'b1;
            mbd_pkg::PH_PRESSED:    o_stat.busy = 1'b1;
            mbd_pkg::PH_RELEASE_DB: o_stat.busy = !release_done;
            default:                o_stat.busy = 1'b0;
        endcase
    end

    always_comb begin
        n_phase = r_phase;
        n_stamp = r_stamp;
        n_valid = r_valid;
        if (o_stat.started) begin
            n_phase = mbd_pkg::PH_PRESS_DB;
            n_stamp = i_cmd.now;
            n_valid = 1'b1;
        end else if (i_cmd.tick) begin
            if (i_clear) begin
                n_valid = 1'b0;
            end
            unique case (r_phase)
                mbd_pkg::PH_PRESS_DB: begin
                    if (press_done) begin
                        if (pressed) begin
                            n_phase = mbd_pkg::PH_PRESSED;
                        end else begin
                            n_phase = mbd_pkg::PH_RELEASE_DB;
                            n_stamp = i_cmd.now;
                            n_valid = 1'b1;
                        end
                    end
                end
                mbd_pkg::PH_PRESSED: begin
                    if (!pressed) begin
                        n_phase = mbd_pkg::PH_RELEASE_DB;
                        n_stamp = i_cmd.now;
                        n_valid = 1'b1;
                    end
                end
                mbd_pkg::PH_RELEASE_DB: begin
                    if (release_done) begin
                        n_phase = mbd_pkg::PH_IDLE;
                        n_valid = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mbd_pkg::PH_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_stamp <= n_stamp;
    end

endmodule

>>> rtl/mbd_merge.sv
`include "multi_button_debouncer_defines.svh"

module mbd_merge #(
    parameter int BUTTON_COUNT = mbd_pkg::BUTTON_COUNT_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbd_pkg::t_merge_req     i_req,
    input  logic [BUTTON_COUNT-1:0] i_comb,
    input  logic                    i_tready,
    output logic                    o_idle,
    output logic                    o_valid,
    output mbd_pkg::t_kind          o_kind,
    output logic [1:0]              o_button,
    output logic                    o_poll_active,
    output logic                    o_last
);

    logic                          r_pend_poll, n_pend_poll;
    logic                          r_pend_press, n_pend_press;
    logic                          r_pend_done, n_pend_done;
    logic [BUTTON_COUNT-1:0]       r_pend_comb, n_pend_comb;
    logic [mbd_pkg::BTN_IDX_W-1:0] r_btn, n_btn;
    logic                          r_polling, n_polling;

    logic                          r_out_valid, n_out_valid;
    mbd_pkg::t_kind                r_out_kind, n_out_kind;
    logic [1:0]                    r_out_btn, n_out_btn;
    logic                          r_out_poll, n_out_poll;
    logic                          r_out_last, n_out_last;

    logic                          pend_any;
    logic                          out_free;
    logic [mbd_pkg::BTN_IDX_W-1:0] low_idx;

    assign pend_any = r_pend_poll || r_pend_press || r_pend_done || (|r_pend_comb);
    assign out_free = !r_out_valid || i_tready;

    // lowest pending combined press
    always_comb begin
        low_idx = '0;
        for (int i = BUTTON_COUNT - 1; i >= 0; i--) begin
            if (r_pend_comb[i]) begin
                low_idx = mbd_pkg::BTN_IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_pend_poll  = r_pend_poll;
        n_pend_press = r_pend_press;
        n_pend_done  = r_pend_done;
        n_pend_comb  = r_pend_comb;
        n_btn        = r_btn;
        n_polling    = r_polling;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_btn    = r_out_btn;
        n_out_poll   = r_out_poll;
        n_out_last   = r_out_last;

        if (out_free) begin
            n_out_valid = pend_any;
            n_out_poll  = r_polling;
            priority if (r_pend_poll) begin
                n_out_kind  = mbd_pkg::KIND_POLL_START;
                n_out_btn   = r_btn[1:0];
                n_out_last  = 1'b0;
                n_pend_poll = 1'b0;
            end else if (r_pend_press) begin
                n_out_kind   = mbd_pkg::KIND_PRESS;
                n_out_btn    = r_btn[1:0];
                n_out_last   = 1'b1;
                n_pend_press = 1'b0;
            end else if (|r_pend_comb) begin
                n_out_kind  = mbd_pkg::KIND_COMBINED;
                n_out_btn   = low_idx[1:0];
                n_out_last  = 1'b0;
                // drop the lowest pending bit
                n_pend_comb = r_pend_comb & (r_pend_comb - BUTTON_COUNT'(1));
            end else begin
                // a pending done gives the last beat; with nothing pending the beat stays invalid
                n_out_kind  = mbd_pkg::KIND_DONE;
                n_out_btn   = 2'd0;
                n_out_last  = 1'b1;
                n_pend_done = 1'b0;
            end
        end

        // loads only happen with nothing queued
        if (i_req.edge_go) begin
            n_pend_poll  = !r_polling;
            n_pend_press = 1'b1;
            n_btn        = i_req.btn;
            n_polling    = 1'b1;
        end else if (i_req.tick) begin
            n_pend_comb = i_comb;
            n_pend_done = 1'b1;
            n_polling   = i_req.busy_any;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_poll  <= 1'b0;
            r_pend_press <= 1'b0;
            r_pend_done  <= 1'b0;
            r_pend_comb  <= '0;
            r_polling    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_pend_poll  <= n_pend_poll;
            r_pend_press <= n_pend_press;
            r_pend_done  <= n_pend_done;
            r_pend_comb  <= n_pend_comb;
            r_polling    <= n_polling;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_btn      <= n_btn;
        r_out_kind <= n_out_kind;
        r_out_btn  <= n_out_btn;
        r_out_poll <= n_out_poll;
        r_out_last <= n_out_last;
    end

    assign o_idle        = !pend_any;
    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_button      = r_out_btn;
    assign o_poll_active = r_out_poll;
    assign o_last        = r_out_last;

    `MBD_ASSERT_IMP(a_load_only_when_empty, i_req.edge_go || i_req.tick, !pend_any)
    `MBD_ASSERT_NEXT(a_tick_queues_done, i_req.tick, r_pend_done)
    `MBD_ASSERT_IMP(a_comb_before_done, |r_pend_comb, r_pend_done)
    `MBD_ASSERT_IMP(a_comb_never_last, r_out_valid && r_out_kind == mbd_pkg::KIND_COMBINED, !r_out_last)

endmodule
